[src/mvle_pkg.sv]
package mvle_pkg;

	localparam int MaxNeighbors = 32;
	localparam int NbrIdxW = $clog2(MaxNeighbors);
	localparam int NbrCntW = $clog2(MaxNeighbors + 1);
	localparam logic [8:0] NoValue = 9'd257;
	localparam logic [15:0] TimerSat = 16'hFFFF;

	typedef enum logic [2:0] {
		PH_IDLE   = 3'd0,
		PH_FIRST  = 3'd1,
		PH_PAUSE  = 3'd2,
		PH_GATHER = 3'd3,
		PH_DONE   = 3'd4
	} phase_t;

	typedef enum logic [2:0] {
		OP_TICK   = 3'd0,
		OP_FOUND  = 3'd1,
		OP_REPORT = 3'd2,
		OP_QUERY  = 3'd3,
		OP_START  = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		K_START    = 2'd0,
		K_ANNOUNCE = 2'd1,
		K_DONE     = 2'd2,
		K_REPLY    = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		REG_MY_ID  = 3'd0,
		REG_MY_VAL = 3'd1,
		REG_STABLE = 3'd2,
		REG_T1     = 3'd3,
		REG_T2     = 3'd4
	} reg_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_WAIT,
		S_EXEC,
		S_OUT
	} seq_t;

	typedef struct packed {
		logic [2:0]  op;
		logic [63:0] node_id;
		logic [63:0] reported_leader;
		logic [7:0]  reported_value;
	} in_word_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  value;
		logic [63:0] leader_id;
		logic        self_leader;
	} out_word_t;

endpackage

[src/mvle_stream_if.sv]
interface mvle_stream_if #(
	parameter type word_t = logic
);
	logic  valid;
	logic  ready;
	word_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

[src/mvle_ram.sv]
module mvle_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

[src/min_value_leader_election.sv]
// channel | dir | word
// in_ch   | in  | op, node_id, reported_leader, reported_value
// out_ch  | out | kind, value, leader_id, self_leader
// cfg     | in  | cfg_we, cfg_index, cfg_data (64 bits)
// Found and report words scan the neighbor table through the registered RAM read
// port, an S_SCAN read and an S_WAIT compare per entry, up to the first match.
// Other words go from S_IDLE to S_EXEC and S_OUT. A result sits in an output
// register and in_ch.ready stays low until it is taken.
// arst_n clears all control state; no clearing pass, the id table is valid up to
// neighbor_count.
module min_value_leader_election (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [2:0]           cfg_index,
	input  logic [63:0]          cfg_data,
	mvle_stream_if.sink          in_ch,
	mvle_stream_if.source        out_ch
);
	import mvle_pkg::*;

	logic [63:0] my_id_q;
	logic [7:0]  my_value_q;
	logic [3:0]  stable_q;
	logic [15:0] t1_ticks_q, t2_ticks_q;

	seq_t seq_q, seq_d;
	in_word_t in_q;
	phase_t phase_q;
	logic [NbrCntW-1:0] ncount_q, hcount_q;
	logic [MaxNeighbors-1:0] heard_q;
	logic [8:0]  best_val_q;
	logic [63:0] best_id_q;
	logic [7:0]  cur_min_q;
	logic [63:0] cur_leader_q;
	logic [3:0]  rounds_q;
	logic [15:0] t1_q, t2_q;
	logic [NbrCntW-1:0] scan_q;
	logic [NbrIdxW-1:0] hit_idx_q;
	logic found_q;
	out_word_t out_q;
	logic out_valid_q;

	logic [63:0] ram_rdata;
	logic        ram_we;
	logic [NbrIdxW-1:0] ram_raddr;

	assign ram_raddr = scan_q[NbrIdxW-1:0];
	assign ram_we = (seq_q == S_EXEC) && (in_q.op == OP_FOUND) && !found_q
		&& (ncount_q < NbrCntW'(MaxNeighbors));

	mvle_ram #(.Width(64), .Depth(MaxNeighbors)) u_ids (
		.clk(clk), .we(ram_we), .waddr(ncount_q[NbrIdxW-1:0]),
		.wdata(in_q.node_id), .raddr(ram_raddr), .rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			my_id_q <= '0;
			my_value_q <= 8'd1;
			stable_q <= 4'd5;
			t1_ticks_q <= 16'd100;
			t2_ticks_q <= 16'd60;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MY_ID:  my_id_q <= cfg_data;
				REG_MY_VAL: my_value_q <= cfg_data[7:0];
				REG_STABLE: stable_q <= cfg_data[3:0];
				REG_T1:     t1_ticks_q <= cfg_data[15:0];
				REG_T2:     t2_ticks_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// S_SCAN issues read of scan_q; S_WAIT compares the registered data.
	always_comb begin
		seq_d = seq_q;
		case (seq_q)
			S_IDLE: if (in_ch.valid && in_ch.ready) begin
				seq_d = (in_ch.data.op inside {OP_FOUND, OP_REPORT}) ? S_SCAN : S_EXEC;
			end
			S_SCAN: seq_d = (scan_q >= ncount_q) ? S_EXEC : S_WAIT;
			S_WAIT: seq_d = (ram_rdata == in_q.node_id) ? S_EXEC : S_SCAN;
			S_EXEC: seq_d = S_OUT;
			S_OUT:  seq_d = S_IDLE;
			default: seq_d = S_IDLE;
		endcase
	end

	always_comb begin
		in_ch.ready = (seq_q == S_IDLE) && !out_valid_q;
		out_ch.valid = out_valid_q;
		out_ch.data = out_q;
	end

	logic [15:0] t1_inc, t2_inc;
	logic        win_closed;
	logic        emit_q;
	kind_t       kind_q;
	assign t1_inc = (t1_q < TimerSat) ? t1_q + 16'd1 : t1_q;
	assign t2_inc = (t2_q < TimerSat) ? t2_q + 16'd1 : t2_q;
	assign win_closed = (hcount_q == ncount_q) || (t2_inc >= t2_ticks_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q <= S_IDLE;
			phase_q <= PH_IDLE;
			ncount_q <= '0;
			hcount_q <= '0;
			heard_q <= '0;
			best_val_q <= NoValue;
			best_id_q <= '0;
			cur_min_q <= '0;
			cur_leader_q <= '0;
			rounds_q <= '0;
			t1_q <= TimerSat;
			t2_q <= '0;
			scan_q <= '0;
			hit_idx_q <= '0;
			found_q <= 1'b0;
			out_valid_q <= 1'b0;
			emit_q <= 1'b0;
			kind_q <= K_START;
		end else begin
			seq_q <= seq_d;
			if (seq_q == S_OUT && emit_q) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.valid && out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			case (seq_q)
				S_IDLE: begin
					scan_q <= '0;
					found_q <= 1'b0;
				end
				S_SCAN: ;
				S_WAIT: begin
					if (ram_rdata == in_q.node_id) begin
						found_q <= 1'b1;
						hit_idx_q <= scan_q[NbrIdxW-1:0];
					end else begin
						scan_q <= scan_q + 1'b1;
					end
				end
				S_EXEC: begin
					case (in_q.op)
						OP_TICK: begin
							if (phase_q == PH_FIRST) begin
								t1_q <= t1_inc;
								if (win_closed) begin
									heard_q <= '0;
									hcount_q <= '0;
									best_val_q <= NoValue;
									best_id_q <= '0;
									t2_q <= '0;
									phase_q <= PH_PAUSE;
								end else begin
									t2_q <= t2_inc;
								end
							end else if (phase_q == PH_PAUSE) begin
								if (t1_inc >= t1_ticks_q) begin
									t1_q <= '0;
									t2_q <= '0;
									phase_q <= PH_GATHER;
								end else begin
									t1_q <= t1_inc;
								end
							end else if (phase_q == PH_GATHER) begin
								t1_q <= t1_inc;
								t2_q <= t2_inc;
								if (win_closed) begin
									emit_q <= 1'b1;
									if (best_val_q < {1'b0, cur_min_q}) begin
										cur_min_q <= best_val_q[7:0];
										cur_leader_q <= best_id_q;
										rounds_q <= stable_q;
										kind_q <= K_ANNOUNCE;
									end else if (best_val_q == {1'b0, cur_min_q}
										&& rounds_q != 4'd0) begin
										rounds_q <= rounds_q - 4'd1;
										if (best_id_q < cur_leader_q) begin
											cur_leader_q <= best_id_q;
										end
										kind_q <= K_ANNOUNCE;
									end else if (rounds_q == 4'd0) begin
										kind_q <= K_DONE;
									end else begin
										kind_q <= K_ANNOUNCE;
									end
									if (!(best_val_q >= {1'b0, cur_min_q}
										&& !(best_val_q == {1'b0, cur_min_q}
										&& rounds_q != 4'd0) && rounds_q == 4'd0)) begin
										heard_q <= '0;
										hcount_q <= '0;
										best_val_q <= NoValue;
										best_id_q <= '0;
										phase_q <= PH_PAUSE;
									end else begin
										phase_q <= PH_DONE;
									end
								end
							end else begin
								t1_q <= t1_inc;
							end
						end
						OP_FOUND: if (ram_we) begin
							ncount_q <= ncount_q + 1'b1;
						end
						OP_REPORT: begin
							if (phase_q != PH_IDLE && phase_q != PH_DONE
								&& in_q.reported_value != 8'd0 && found_q) begin
								if (!heard_q[hit_idx_q]) begin
									heard_q[hit_idx_q] <= 1'b1;
									hcount_q <= hcount_q + 1'b1;
								end
								if ({1'b0, in_q.reported_value} < best_val_q) begin
									best_val_q <= {1'b0, in_q.reported_value};
									best_id_q <= in_q.reported_leader;
								end
							end
						end
						OP_QUERY: begin
							emit_q <= 1'b1;
							kind_q <= K_REPLY;
						end
						OP_START: begin
							if (phase_q == PH_IDLE && ncount_q != '0) begin
								cur_min_q <= my_value_q;
								cur_leader_q <= my_id_q;
								rounds_q <= stable_q;
								heard_q <= '0;
								hcount_q <= '0;
								best_val_q <= NoValue;
								best_id_q <= '0;
								t2_q <= '0;
								phase_q <= PH_FIRST;
								emit_q <= 1'b1;
								kind_q <= K_START;
							end
						end
						default: ;
					endcase
				end
				S_OUT: begin
					emit_q <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (seq_q == S_IDLE && in_ch.valid && in_ch.ready) begin
			in_q <= in_ch.data;
		end
		if (seq_q == S_OUT) begin
			out_q.kind <= kind_q;
			out_q.value <= cur_min_q;
			out_q.leader_id <= cur_leader_q;
			out_q.self_leader <= (cur_leader_q == my_id_q);
		end
	end

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(seq_q != S_IDLE) |-> !in_ch.ready)
		else $error("accept while busy");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		hcount_q <= ncount_q)
		else $error("heard count above neighbor count");
	a_ncount_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ncount_q <= NbrCntW'(MaxNeighbors))
		else $error("neighbor table overflow");
	a_heard_ones: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(heard_q) == int'(hcount_q))
		else $error("heard flags and count disagree");
endmodule
